// ----- rtl/energy_voice_activity_detector_unit_defines.svh -----
// assertion macros shared by the detector checker
// depends on a clock named i_clk and a reset named i_rst_n in the using scope
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EVAD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EVAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked during reset as well
`define EVAD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/evad_pkg.sv -----
// types and constants of the energy voice activity detector
// no dependencies
package evad_pkg;

    typedef enum logic [1:0] {
        EV_SILENCE       = 2'd0,
        EV_VOICE_BEGIN   = 2'd1,
        EV_VOICE         = 2'd2,
        EV_SILENCE_BEGIN = 2'd3
    } t_event;

    typedef enum logic {
        PH_SILENCE = 1'b0,
        PH_VOICE   = 1'b1
    } t_phase;

    typedef enum logic [1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_SLICE_LEN   = 2'd1,
        CFG_VOICE_RUN   = 2'd2,
        CFG_SILENCE_RUN = 2'd3
    } t_cfg_index;

    localparam logic [15:0] THRESHOLD_RST   = 16'd200;
    localparam logic [15:0] SLICE_LEN_RST   = 16'd80;
    localparam logic [15:0] VOICE_RUN_RST   = 16'd2;
    localparam logic [15:0] SILENCE_RUN_RST = 16'd20;
    localparam logic [31:0] LIMIT_RST       = 32'd16000;

endpackage

// ----- rtl/energy_voice_activity_detector_unit.sv -----
// energy voice activity detector: slice energy, voice/silence hangover machine
// depends on evad_pkg
// a result passes through the input register and then the result register
// throughput: one sample per cycle while the result is not stalled; the input pauses after each
// configuration transfer while the threshold times length product register reloads
// a sample that ends no event-producing slice yields no result transfer
// synchronous active-low reset restores register defaults and clears all counters
module energy_voice_activity_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [31:0] o_sample_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [15:0] r_threshold;
    logic [15:0] r_slice_len;
    logic [15:0] r_voice_run;
    logic [15:0] r_silence_run;
    logic [31:0] r_limit;
    logic        r_cfg_hold;

    // input stage
    logic        r_in_valid;
    logic [15:0] r_sample;

    // running state
    evad_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_sum;
    logic [15:0] r_fill;
    logic [15:0] r_run, n_run;
    logic [31:0] r_total;

    // result stage
    logic              r_out_valid;
    evad_pkg::t_event  r_event, n_event;
    logic [31:0]       r_count;

    logic        cfg_xfer;
    logic        in_xfer;
    logic        advance;
    logic        work;
    logic [16:0] mag;
    logic [31:0] sum_acc;
    logic [15:0] fill_inc;
    logic [15:0] run_inc;
    logic [31:0] total_inc;
    logic        slice_end;
    logic        voice_slice;
    logic        emit;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign advance     = !r_out_valid || i_ready;
    assign work        = r_in_valid && advance;
    assign o_ready     = !r_cfg_hold && (!r_in_valid || advance);
    assign in_xfer     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= evad_pkg::THRESHOLD_RST;
            r_slice_len   <= evad_pkg::SLICE_LEN_RST;
            r_voice_run   <= evad_pkg::VOICE_RUN_RST;
            r_silence_run <= evad_pkg::SILENCE_RUN_RST;
            r_limit       <= evad_pkg::LIMIT_RST;
            r_cfg_hold    <= 1'b0;
        end else begin
            r_cfg_hold <= cfg_xfer;
            r_limit    <= {16'd0, r_threshold} * {16'd0, r_slice_len};
            if (cfg_xfer) begin
                unique case (evad_pkg::t_cfg_index'(i_cfg_index))
                    evad_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                    evad_pkg::CFG_SLICE_LEN:   r_slice_len   <= i_cfg_data;
                    evad_pkg::CFG_VOICE_RUN:   r_voice_run   <= i_cfg_data;
                    evad_pkg::CFG_SILENCE_RUN: r_silence_run <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // magnitude of the most negative sample is 32768, hence 17 bits
    assign mag       = r_sample[15] ? (17'd0 - {r_sample[15], r_sample}) : {1'b0, r_sample};
    assign sum_acc   = r_sum + {15'd0, mag};
    assign fill_inc  = r_fill + 16'd1;
    assign run_inc   = r_run + 16'd1;
    assign total_inc = r_total + 32'd1;
    assign slice_end = fill_inc >= r_slice_len;
    assign voice_slice = sum_acc > r_limit;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (slice_end) begin
            unique case (r_phase)
                evad_pkg::PH_SILENCE: begin
                    if (voice_slice && run_inc >= r_voice_run) n_phase = evad_pkg::PH_VOICE;
                end
                evad_pkg::PH_VOICE: begin
                    if (!voice_slice && run_inc >= r_silence_run) n_phase = evad_pkg::PH_SILENCE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // event, emit and run counter
    always_comb begin
        n_event = evad_pkg::EV_SILENCE;
        n_run   = r_run;
        emit    = 1'b0;
        if (slice_end) begin
            unique case (r_phase)
                evad_pkg::PH_SILENCE: begin
                    if (voice_slice) begin
                        n_run = run_inc;
                        if (run_inc >= r_voice_run) begin
                            n_run   = 16'd0;
                            n_event = evad_pkg::EV_VOICE_BEGIN;
                            emit    = 1'b1;
                        end
                    end else begin
                        n_run = 16'd0;
                        emit  = 1'b1;
                    end
                end
                evad_pkg::PH_VOICE: begin
                    if (voice_slice) begin
                        n_run   = 16'd0;
                        n_event = evad_pkg::EV_VOICE;
                        emit    = 1'b1;
                    end else begin
                        n_run = run_inc;
                        if (run_inc >= r_silence_run) begin
                            n_run   = 16'd0;
                            n_event = evad_pkg::EV_SILENCE_BEGIN;
                            emit    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= evad_pkg::PH_SILENCE;
            r_sum       <= 32'd0;
            r_fill      <= 16'd0;
            r_run       <= 16'd0;
            r_total     <= 32'd0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (work) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= work && emit;
            end
            if (work) begin
                r_phase <= n_phase;
                r_run   <= n_run;
                r_total <= total_inc;
                r_sum   <= slice_end ? 32'd0 : sum_acc;
                r_fill  <= slice_end ? 16'd0 : fill_inc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_sample;
        end
        if (work) begin
            r_event <= n_event;
            r_count <= total_inc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_res    = r_event;
    assign o_sample_count = r_count;

endmodule

// ----- rtl/evad_checker.sv -----
// port-level checker for the energy voice activity detector, bound to the top level
// depends on energy_voice_activity_detector_unit_defines.svh
`include "energy_voice_activity_detector_unit_defines.svh"

module evad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_event_res,
    input logic [31:0] o_sample_count,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // a stalled result keeps its payload
    `EVAD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_event_res) && $stable(o_sample_count), "stalled result changed")

    // no result right after reset
    `EVAD_ASSERT_ALWAYS(a_reset_quiet, !$past(i_rst_n), !o_valid, "result valid after reset")

    // input is held off in the cycle after a configuration transfer
    `EVAD_ASSERT_NEXT(a_cfg_pause, i_cfg_valid && o_cfg_ready, !o_ready, "input ready after config transfer")

    // input is taken whenever no result waits and no configuration pause applies
    `EVAD_ASSERT_SAME(a_ready_free, i_valid && !o_valid && !$past(i_cfg_valid && o_cfg_ready), o_ready, "input refused while free")

endmodule

bind energy_voice_activity_detector_unit evad_checker u_evad_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_event_res    (o_event_res),
    .o_sample_count (o_sample_count),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);
